[rtl/gbts_pkg.sv]
// ----------------------------------------------------------------------------
// gbts_pkg
// Shared widths, operation codes and status codes for the gap buffer store.
// ----------------------------------------------------------------------------
package gbts_pkg;

  localparam int CAPACITY_DEF = 4096;

  localparam int DATA_W   = 8;
  localparam int FIELD_W  = 13;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  localparam logic [KIND_W-1:0] KIND_INSERT     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DEL_BEFORE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_AFTER  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_MOVE       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_READ       = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE  = 2'd3;

endpackage

[rtl/gap_buffer_text_store_core.sv]
// ----------------------------------------------------------------------------
// gap_buffer_text_store_core
// Fixed-capacity gap buffer text store: insert, delete before/after the
// cursor, move the cursor, read a byte at a logical position.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Insert, both deletes and any
// rejected operation finish in the execute state; a read also waits for the
// registered read of the byte store; a cursor move copies one byte across the
// gap per cycle through the store's single read port and single write port.
// A new transaction is taken as soon as the previous one has finished its
// work, even while its result still waits at the output register.
module gap_buffer_text_store_core #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbts_pkg::KIND_W-1:0]   kind,
  input  logic [gbts_pkg::FIELD_W-1:0]  pos,
  input  logic [gbts_pkg::DATA_W-1:0]   ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbts_pkg::STATUS_W-1:0] status,
  output logic [gbts_pkg::DATA_W-1:0]   ch_out,
  output logic [gbts_pkg::FIELD_W-1:0]  text_length,
  output logic [gbts_pkg::FIELD_W-1:0]  cursor
);
  import gbts_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  gbts_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .pos         (pos),
    .ch          (ch),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .ch_out      (ch_out),
    .text_length (text_length),
    .cursor      (cursor),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  gbts_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

[rtl/gbts_mem.sv]
// ----------------------------------------------------------------------------
// gbts_mem
// Byte store: one write port, one read port, registered read data that
// holds while no read is issued.
// ----------------------------------------------------------------------------
module gbts_mem #(
  parameter int DEPTH = gbts_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [gbts_pkg::DATA_W-1:0] wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [gbts_pkg::DATA_W-1:0] rdata
);
  import gbts_pkg::*;

  logic [DATA_W-1:0] store [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= store[raddr];
    end
  end

endmodule

[rtl/gbts_ctrl.sv]
// ----------------------------------------------------------------------------
// gbts_ctrl
// Operation sequencer: gap pointers, text length, byte-by-byte gap shifting
// through the store, and the registered result.
// ----------------------------------------------------------------------------
module gbts_ctrl #(
  parameter int CAPACITY = gbts_pkg::CAPACITY_DEF,
  parameter int AW       = $clog2(CAPACITY)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gbts_pkg::KIND_W-1:0]   kind,
  input  logic [gbts_pkg::FIELD_W-1:0]  pos,
  input  logic [gbts_pkg::DATA_W-1:0]   ch,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gbts_pkg::STATUS_W-1:0] status,
  output logic [gbts_pkg::DATA_W-1:0]   ch_out,
  output logic [gbts_pkg::FIELD_W-1:0]  text_length,
  output logic [gbts_pkg::FIELD_W-1:0]  cursor,
  output logic                          mem_we,
  output logic [AW-1:0]                 mem_waddr,
  output logic [gbts_pkg::DATA_W-1:0]   mem_wdata,
  output logic                          mem_re,
  output logic [AW-1:0]                 mem_raddr,
  input  logic [gbts_pkg::DATA_W-1:0]   mem_rdata
);
  import gbts_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int CW = (PW > FIELD_W) ? PW : FIELD_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOVE,
    ST_READ
  } state_t;

  state_t              state;
  logic [KIND_W-1:0]   kind_q;
  logic [FIELD_W-1:0]  pos_q;
  logic [DATA_W-1:0]   ch_q;
  logic [PW-1:0]       gap_first;
  logic [PW-1:0]       gap_past;
  logic [PW-1:0]       text_len;
  logic                wr_pend;
  logic [AW-1:0]       wr_addr;

  logic [CW-1:0]       pos_w;
  logic [CW-1:0]       gf_w;
  logic [CW-1:0]       gp_w;
  logic [CW-1:0]       len_w;
  logic [CW-1:0]       rd_addr_w;
  logic [PW-1:0]       gf_dec;
  logic [PW-1:0]       gf_inc;
  logic [PW-1:0]       gp_dec;
  logic [PW-1:0]       gp_inc;
  logic [PW-1:0]       len_dec;
  logic [PW-1:0]       len_inc;
  logic                out_free;
  logic                at_target;
  logic                move_left;
  logic                is_full;

  function automatic logic [FIELD_W-1:0] to_field(input logic [CW-1:0] v);
    return v[FIELD_W-1:0];
  endfunction

  assign pos_w     = CW'(pos_q);
  assign gf_w      = CW'(gap_first);
  assign gp_w      = CW'(gap_past);
  assign len_w     = CW'(text_len);
  assign gf_dec    = PW'(gap_first - 1'b1);
  assign gf_inc    = PW'(gap_first + 1'b1);
  assign gp_dec    = PW'(gap_past - 1'b1);
  assign gp_inc    = PW'(gap_past + 1'b1);
  assign len_dec   = PW'(text_len - 1'b1);
  assign len_inc   = PW'(text_len + 1'b1);
  assign out_free  = !out_valid || out_ready;
  assign at_target = (gf_w == pos_w);
  assign move_left = (gf_w > pos_w);
  assign is_full   = (text_len == PW'(CAPACITY));
  assign rd_addr_w = (pos_w < gf_w) ? pos_w : CW'(pos_w + gp_w - gf_w);

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = rd_addr_w[AW-1:0];
    if (state == ST_MOVE) begin
      mem_re    = !at_target;
      mem_raddr = move_left ? gf_dec[AW-1:0] : gap_past[AW-1:0];
    end else if (state == ST_EXEC) begin
      mem_re = (kind_q == KIND_READ) && (pos_w < len_w) && out_free;
    end
  end

  always_comb begin
    mem_we    = wr_pend;
    mem_waddr = wr_addr;
    mem_wdata = mem_rdata;
    if (!wr_pend) begin
      mem_we    = (state == ST_EXEC) && (kind_q == KIND_INSERT) && !is_full && out_free;
      mem_waddr = gap_first[AW-1:0];
      mem_wdata = ch_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gap_first <= '0;
      gap_past  <= PW'(CAPACITY);
      text_len  <= '0;
      wr_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      wr_pend <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            pos_q  <= pos;
            ch_q   <= ch;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= STATUS_OK;
            ch_out      <= '0;
            text_length <= to_field(len_w);
            cursor      <= to_field(gf_w);
            state       <= ST_IDLE;
            case (kind_q)
              KIND_INSERT: begin
                if (is_full) begin
                  status <= STATUS_FULL;
                end else begin
                  gap_first   <= gf_inc;
                  text_len    <= len_inc;
                  text_length <= to_field(CW'(len_inc));
                  cursor      <= to_field(CW'(gf_inc));
                end
              end
              KIND_DEL_BEFORE: begin
                if (gap_first == '0) begin
                  status <= STATUS_EMPTY;
                end else begin
                  gap_first   <= gf_dec;
                  text_len    <= len_dec;
                  text_length <= to_field(CW'(len_dec));
                  cursor      <= to_field(CW'(gf_dec));
                end
              end
              KIND_DEL_AFTER: begin
                if (gap_past == PW'(CAPACITY)) begin
                  status <= STATUS_EMPTY;
                end else begin
                  gap_past    <= gp_inc;
                  text_len    <= len_dec;
                  text_length <= to_field(CW'(len_dec));
                end
              end
              KIND_MOVE: begin
                if (pos_w > len_w) begin
                  status <= STATUS_RANGE;
                end else begin
                  out_valid <= out_valid && !out_ready;
                  state     <= ST_MOVE;
                end
              end
              KIND_READ: begin
                if (pos_w >= len_w) begin
                  status <= STATUS_RANGE;
                end else begin
                  out_valid <= out_valid && !out_ready;
                  state     <= ST_READ;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MOVE: begin
          if (!at_target) begin
            // shift one byte across the gap; write it back next cycle
            wr_pend <= 1'b1;
            if (move_left) begin
              wr_addr   <= gp_dec[AW-1:0];
              gap_first <= gf_dec;
              gap_past  <= gp_dec;
            end else begin
              wr_addr   <= gap_first[AW-1:0];
              gap_first <= gf_inc;
              gap_past  <= gp_inc;
            end
          end else if (out_free) begin
            out_valid   <= 1'b1;
            status      <= STATUS_OK;
            ch_out      <= '0;
            text_length <= to_field(len_w);
            cursor      <= to_field(gf_w);
            state       <= ST_IDLE;
          end
        end
        ST_READ: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= STATUS_OK;
            ch_out      <= mem_rdata;
            text_length <= to_field(len_w);
            cursor      <= to_field(gf_w);
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
